// ===== rtl/fr_pkg.sv =====
// Shared types and constants for the Fresnel reflectance block.
// Holds the transaction structs, the fixed-point widths and the register indexes.
// No dependencies.
package fr_pkg;

  // Field widths of the transactions.
  localparam int unsigned VEC_WIDTH = 16;
  localparam int unsigned OUT_WIDTH = 16;

  // Internal fixed point: cosines and sines carry FRAC fractional bits.
  localparam int unsigned FRAC     = 28;
  localparam int unsigned C_W      = FRAC + 1;
  localparam int unsigned SQ_IN_W  = 2 * FRAC + 2;
  localparam int unsigned PROD_W   = VEC_WIDTH + C_W;
  localparam int unsigned DEN_W    = PROD_W + 1;
  localparam int unsigned NORM_W   = 32;
  localparam int unsigned SH_W     = $clog2(DEN_W - NORM_W + 1);
  localparam int unsigned R_Q      = 30;
  localparam int unsigned R_W      = R_Q + 1;
  localparam int unsigned KR_SHIFT = 2 * R_Q + 1 - OUT_WIDTH;

  // Queue between the front and the back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 3);

  localparam logic [C_W-1:0]       UNIT     = {1'b1, {FRAC{1'b0}}};
  localparam logic [SQ_IN_W-1:0]   SQ_ONE   = {2'b01, {(2 * FRAC){1'b0}}};
  localparam logic [OUT_WIDTH-1:0] REFL_ONE = {1'b1, {(OUT_WIDTH - 1){1'b0}}};

  localparam logic [VEC_WIDTH-1:0] OUTER_RESET = 16'd16384;
  localparam logic [VEC_WIDTH-1:0] INNER_RESET = 16'd18022;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_OUTER = 1'b0,
    REG_INNER = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic signed [VEC_WIDTH-1:0] dir_x;
    logic signed [VEC_WIDTH-1:0] dir_y;
    logic signed [VEC_WIDTH-1:0] dir_z;
    logic signed [VEC_WIDTH-1:0] norm_x;
    logic signed [VEC_WIDTH-1:0] norm_y;
    logic signed [VEC_WIDTH-1:0] norm_z;
    logic                        ray_inside;
  } in_item_t;

  typedef struct packed {
    logic [OUT_WIDTH-1:0] reflectance;
    logic                 total_internal;
  } out_item_t;

  // Classified work handed from the front to the back.
  typedef struct packed {
    logic [C_W-1:0]       cos_i;
    logic [VEC_WIDTH-1:0] eta_i;
    logic [VEC_WIDTH-1:0] eta_t;
  } work_t;

endpackage

// ===== rtl/fr_sqrt_pipe.sv =====
// Pipelined integer square root, two result bits per stage, with a sideband.
// Depends on nothing; instantiated by fr_back.
module fr_sqrt_pipe #(
  parameter int unsigned IN_W   = 58,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [IN_W-1:0]     rad_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic [IN_W/2-1:0]   root_o,
  output logic [SIDE_W-1:0]   side_o
);

  localparam int unsigned OUT_W = IN_W / 2;
  localparam int unsigned SPS   = 2;
  localparam int unsigned NST   = (OUT_W + SPS - 1) / SPS;
  localparam int unsigned RW    = OUT_W + 4;

  logic              v_q    [NST];
  logic [IN_W-1:0]   rad_q  [NST];
  logic [RW-1:0]     rem_q  [NST];
  logic [OUT_W-1:0]  root_q [NST];
  logic [SIDE_W-1:0] side_q [NST];

  logic              v_in    [NST];
  logic [IN_W-1:0]   rad_in  [NST];
  logic [RW-1:0]     rem_in  [NST];
  logic [OUT_W-1:0]  root_in [NST];
  logic [SIDE_W-1:0] side_in [NST];

  logic [IN_W-1:0]   rad_d  [NST];
  logic [RW-1:0]     rem_d  [NST];
  logic [OUT_W-1:0]  root_d [NST];

  // Each stage takes its operands from the stage before it.
  always_comb begin
    v_in[0]    = valid_i;
    rad_in[0]  = rad_i;
    rem_in[0]  = '0;
    root_in[0] = '0;
    side_in[0] = side_i;
    for (int s = 1; s < NST; s++) begin
      v_in[s]    = v_q[s-1];
      rad_in[s]  = rad_q[s-1];
      rem_in[s]  = rem_q[s-1];
      root_in[s] = root_q[s-1];
      side_in[s] = side_q[s-1];
    end
  end

  // Restoring digit-by-digit root: bring down two radicand bits per step.
  always_comb begin
    logic [IN_W-1:0]  rad;
    logic [RW-1:0]    rem;
    logic [RW-1:0]    trial;
    logic [OUT_W-1:0] root;
    for (int s = 0; s < NST; s++) begin
      rad  = rad_in[s];
      rem  = rem_in[s];
      root = root_in[s];
      for (int j = 0; j < SPS; j++) begin
        if (s * SPS + j < OUT_W) begin
          rem   = {rem[RW-3:0], rad[IN_W-1 -: 2]};
          rad   = {rad[IN_W-3:0], 2'b00};
          trial = {{(RW - OUT_W - 2){1'b0}}, root, 2'b01};
          if (rem >= trial) begin
            rem  = rem - trial;
            root = {root[OUT_W-2:0], 1'b1};
          end else begin
            root = {root[OUT_W-2:0], 1'b0};
          end
        end
      end
      rad_d[s]  = rad;
      rem_d[s]  = rem;
      root_d[s] = root;
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NST; s++) v_q[s] <= 1'b0;
    end else if (en_i) begin
      for (int s = 0; s < NST; s++) v_q[s] <= v_in[s];
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NST; s++) begin
        rad_q[s]  <= rad_d[s];
        rem_q[s]  <= rem_d[s];
        root_q[s] <= root_d[s];
        side_q[s] <= side_in[s];
      end
    end
  end

  assign valid_o = v_q[NST-1];
  assign root_o  = root_q[NST-1];
  assign side_o  = side_q[NST-1];

endmodule

// ===== rtl/fr_div_pipe.sv =====
// Pipelined restoring divider, two quotient bits per stage, one or more lanes.
// Depends on nothing; instantiated by fr_back.
module fr_div_pipe #(
  parameter int unsigned NW     = 45,
  parameter int unsigned DW     = 16,
  parameter int unsigned QB     = 28,
  parameter int unsigned LANES  = 1,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [LANES-1:0][NW-1:0]    num_i,
  input  logic [LANES-1:0][DW-1:0]    den_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        valid_o,
  output logic [LANES-1:0][QB-1:0]    quo_o,
  output logic [SIDE_W-1:0]           side_o
);

  localparam int unsigned SPS = 2;
  localparam int unsigned NST = (QB + SPS - 1) / SPS;

  logic                     v_q    [NST];
  logic [LANES-1:0][DW-1:0] rem_q  [NST];
  logic [LANES-1:0][QB-1:0] lo_q   [NST];
  logic [LANES-1:0][QB-1:0] quo_q  [NST];
  logic [LANES-1:0][DW-1:0] den_q  [NST];
  logic [SIDE_W-1:0]        side_q [NST];

  logic                     v_in    [NST];
  logic [LANES-1:0][DW-1:0] rem_in  [NST];
  logic [LANES-1:0][QB-1:0] lo_in   [NST];
  logic [LANES-1:0][QB-1:0] quo_in  [NST];
  logic [LANES-1:0][DW-1:0] den_in  [NST];
  logic [SIDE_W-1:0]        side_in [NST];

  logic [LANES-1:0][DW-1:0] rem_d [NST];
  logic [LANES-1:0][QB-1:0] lo_d  [NST];
  logic [LANES-1:0][QB-1:0] quo_d [NST];

  // The first stage starts from the upper numerator bits, which are below the divisor.
  always_comb begin
    logic [NW-1:0] hi;
    v_in[0]    = valid_i;
    side_in[0] = side_i;
    for (int l = 0; l < LANES; l++) begin
      hi            = num_i[l] >> QB;
      rem_in[0][l]  = hi[DW-1:0];
      lo_in[0][l]   = num_i[l][QB-1:0];
      quo_in[0][l]  = '0;
      den_in[0][l]  = den_i[l];
    end
    for (int s = 1; s < NST; s++) begin
      v_in[s]    = v_q[s-1];
      rem_in[s]  = rem_q[s-1];
      lo_in[s]   = lo_q[s-1];
      quo_in[s]  = quo_q[s-1];
      den_in[s]  = den_q[s-1];
      side_in[s] = side_q[s-1];
    end
  end

  // Shift in one numerator bit, subtract the divisor when it fits.
  always_comb begin
    logic [DW:0]   t;
    logic [DW-1:0] rem;
    logic [QB-1:0] lo;
    logic [QB-1:0] quo;
    for (int s = 0; s < NST; s++) begin
      for (int l = 0; l < LANES; l++) begin
        rem = rem_in[s][l];
        lo  = lo_in[s][l];
        quo = quo_in[s][l];
        for (int j = 0; j < SPS; j++) begin
          if (s * SPS + j < QB) begin
            t  = {rem, lo[QB-1]};
            lo = {lo[QB-2:0], 1'b0};
            if (t >= {1'b0, den_in[s][l]}) begin
              t   = t - {1'b0, den_in[s][l]};
              quo = {quo[QB-2:0], 1'b1};
            end else begin
              quo = {quo[QB-2:0], 1'b0};
            end
            rem = t[DW-1:0];
          end
        end
        rem_d[s][l] = rem;
        lo_d[s][l]  = lo;
        quo_d[s][l] = quo;
      end
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NST; s++) v_q[s] <= 1'b0;
    end else if (en_i) begin
      for (int s = 0; s < NST; s++) v_q[s] <= v_in[s];
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NST; s++) begin
        rem_q[s]  <= rem_d[s];
        lo_q[s]   <= lo_d[s];
        quo_q[s]  <= quo_d[s];
        den_q[s]  <= den_in[s];
        side_q[s] <= side_in[s];
      end
    end
  end

  assign valid_o = v_q[NST-1];
  assign quo_o   = quo_q[NST-1];
  assign side_o  = side_q[NST-1];

endmodule

// ===== rtl/fr_front.sv =====
// Front end: takes input transactions, forms the incidence cosine and picks the indices.
// Depends on fr_pkg; feeds fr_queue.
module fr_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  fr_pkg::in_item_t            in_data_i,
  input  logic [fr_pkg::VEC_WIDTH-1:0] outer_i,
  input  logic [fr_pkg::VEC_WIDTH-1:0] inner_i,
  input  logic [fr_pkg::QCNT_W-1:0]   q_count_i,
  output logic                        push_o,
  output fr_pkg::work_t               push_data_o
);

  localparam int unsigned P_W    = 2 * fr_pkg::VEC_WIDTH;
  localparam int unsigned TERM_W = 32;
  localparam int unsigned DOT_W  = TERM_W + 2;

  // Scale a raw product to Q.28, truncating toward zero.
  function automatic logic signed [TERM_W-1:0] to_q28(input logic signed [P_W-1:0] p);
    logic signed [63:0] w;
    w = 64'(p) <<< (64 - P_W);
    if (w[63]) begin
      w = w + 64'sd4294967295;
    end
    return w[63 -: TERM_W];
  endfunction

  logic                              accept;
  logic                              f1_v_q, f1_v_d;
  logic signed [P_W-1:0]             p0_q, p1_q, p2_q;
  logic [fr_pkg::VEC_WIDTH-1:0]      eta_i_q, eta_t_q;
  logic                              f2_v_q;
  fr_pkg::work_t                     work_q, work_d;

  // Hold off new transactions once queue entries plus those in flight fill the queue.
  assign in_stall_o = (q_count_i + fr_pkg::QCNT_W'(f1_v_q) + fr_pkg::QCNT_W'(f2_v_q))
                      >= fr_pkg::QCNT_W'(fr_pkg::QUEUE_DEPTH);
  assign accept = in_valid_i && !in_stall_o;
  assign f1_v_d = accept;

  // Sum the three terms and take the saturated magnitude of the cosine.
  always_comb begin
    logic signed [DOT_W-1:0] dot;
    logic [DOT_W-1:0]        mag;
    dot = DOT_W'(to_q28(p0_q)) + DOT_W'(to_q28(p1_q)) + DOT_W'(to_q28(p2_q));
    mag = dot[DOT_W-1] ? DOT_W'(-dot) : DOT_W'(dot);
    work_d.cos_i = (mag > DOT_W'(fr_pkg::UNIT)) ? fr_pkg::UNIT : mag[fr_pkg::C_W-1:0];
    work_d.eta_i = eta_i_q;
    work_d.eta_t = eta_t_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
    end else begin
      f1_v_q <= f1_v_d;
      f2_v_q <= f1_v_q;
    end
  end

  // Products of the components, and the indices swapped for a ray inside the object.
  always_ff @(posedge clk_i) begin
    p0_q    <= in_data_i.dir_x * in_data_i.norm_x;
    p1_q    <= in_data_i.dir_y * in_data_i.norm_y;
    p2_q    <= in_data_i.dir_z * in_data_i.norm_z;
    eta_i_q <= in_data_i.ray_inside ? inner_i : outer_i;
    eta_t_q <= in_data_i.ray_inside ? outer_i : inner_i;
    work_q  <= work_d;
  end

  assign push_o      = f2_v_q;
  assign push_data_o = work_q;

endmodule

// ===== rtl/fr_queue.sv =====
// Small FIFO that decouples the front end from the back end.
// Depends on fr_pkg.
module fr_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  fr_pkg::work_t             push_data_i,
  input  logic                      pop_i,
  output fr_pkg::work_t             head_o,
  output logic                      empty_o,
  output logic [fr_pkg::QCNT_W-1:0] count_o
);

  fr_pkg::work_t                     mem_q [fr_pkg::QUEUE_DEPTH];
  logic [fr_pkg::QPTR_W-1:0]         wr_ptr_q, rd_ptr_q;
  logic [fr_pkg::QCNT_W-1:0]         count_q, count_d;

  // Occupancy follows pushes and pops.
  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

endmodule

// ===== rtl/fr_back.sv =====
// Back end: transmitted angle, Fresnel coefficients and the averaged reflectance.
// Depends on fr_pkg, fr_sqrt_pipe and fr_div_pipe; drains fr_queue.
module fr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  fr_pkg::work_t     head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fr_pkg::out_item_t out_data_o
);

  localparam int unsigned WORK_W = $bits(fr_pkg::work_t);
  localparam int unsigned DIV2_N = fr_pkg::NORM_W + fr_pkg::R_Q;

  typedef struct packed {
    logic          tir;
    fr_pkg::work_t work;
  } mid_t;

  // Amount to shift a denominator right so that it fits the normalized width.
  function automatic logic [fr_pkg::SH_W-1:0] norm_shift(input logic [fr_pkg::DEN_W-1:0] den);
    logic [fr_pkg::SH_W-1:0] s;
    s = '0;
    for (int i = fr_pkg::NORM_W; i < fr_pkg::DEN_W; i++) begin
      if (den[i]) s = fr_pkg::SH_W'(i - fr_pkg::NORM_W + 1);
    end
    return s;
  endfunction

  logic adv;

  // Stage A: one minus the squared cosine.
  logic                          a_v_q;
  logic [fr_pkg::SQ_IN_W-1:0]    a_x_q, a_x_d;
  fr_pkg::work_t                 a_w_q;

  // Sine of incidence.
  logic                          s1_v;
  logic [fr_pkg::C_W-1:0]        s1_root;
  fr_pkg::work_t                 s1_w;

  // Stage B: scaled sine and the total internal reflection test.
  logic                          b_v_q;
  logic [fr_pkg::PROD_W-1:0]     b_pi_q, b_pi_d;
  mid_t                          b_m_q, b_m_d;

  // Transmitted sine.
  logic                          d1_v;
  logic [0:0][fr_pkg::FRAC-1:0]  d1_quo;
  mid_t                          d1_m;

  // Stage C: one minus the squared transmitted sine.
  logic                          c_v_q;
  logic [fr_pkg::SQ_IN_W-1:0]    c_x_q, c_x_d;
  mid_t                          c_m_q;

  // Transmitted cosine.
  logic                          s2_v;
  logic [fr_pkg::C_W-1:0]        s2_root;
  mid_t                          s2_m;

  // Stage D: the four index products.
  logic                          d_v_q, d_tir_q;
  logic [fr_pkg::PROD_W-1:0]     d_as_q, d_bs_q, d_ap_q, d_bp_q;

  // Stage E: numerators and denominators.
  logic                          e_v_q, e_tir_q, e_zero_q;
  logic [fr_pkg::PROD_W-1:0]     e_ns_q, e_np_q;
  logic [fr_pkg::DEN_W-1:0]      e_ds_q, e_dp_q;

  // Stage F: normalizing shifts.
  logic                          f_v_q, f_tir_q, f_zero_q;
  logic [fr_pkg::PROD_W-1:0]     f_ns_q, f_np_q;
  logic [fr_pkg::DEN_W-1:0]      f_ds_q, f_dp_q;
  logic [fr_pkg::SH_W-1:0]       f_ss_q, f_sp_q;

  // Stage G: normalized division operands.
  logic                          g_v_q, g_tir_q, g_zero_q;
  logic [1:0][DIV2_N-1:0]        g_num_q, g_num_d;
  logic [1:0][fr_pkg::NORM_W-1:0] g_den_q, g_den_d;

  // Coefficients.
  logic                          d2_v;
  logic [1:0][fr_pkg::R_W-1:0]   d2_quo;
  logic [1:0]                    d2_flags;

  // Stage H: squared coefficients.
  logic                          h_v_q, h_tir_q, h_zero_q;
  logic [2*fr_pkg::R_W-1:0]      h_ss_q, h_sp_q;

  // Output register.
  logic                          out_v_q;
  fr_pkg::out_item_t             out_q, out_d;

  // The whole back end holds while a finished result waits.
  assign adv   = !(out_v_q && out_stall_i);
  assign pop_o = adv && !empty_i;

  always_comb begin
    logic [2*fr_pkg::C_W-1:0] csq;
    csq   = head_i.cos_i * head_i.cos_i;
    a_x_d = fr_pkg::SQ_ONE - fr_pkg::SQ_IN_W'(csq);
  end

  fr_sqrt_pipe #(
    .IN_W   (fr_pkg::SQ_IN_W),
    .SIDE_W (WORK_W)
  ) u_sqrt_sin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (a_v_q),
    .rad_i   (a_x_q),
    .side_i  (a_w_q),
    .valid_o (s1_v),
    .root_o  (s1_root),
    .side_o  (s1_w)
  );

  // Total internal reflection when the scaled sine reaches the transmitted index.
  always_comb begin
    logic [fr_pkg::PROD_W-1:0] thr;
    b_pi_d     = s1_w.eta_i * s1_root;
    thr        = {1'b0, s1_w.eta_t, {fr_pkg::FRAC{1'b0}}};
    b_m_d.tir  = (b_pi_d >= thr);
    b_m_d.work = s1_w;
  end

  fr_div_pipe #(
    .NW     (fr_pkg::PROD_W),
    .DW     (fr_pkg::VEC_WIDTH),
    .QB     (fr_pkg::FRAC),
    .LANES  (1),
    .SIDE_W ($bits(mid_t))
  ) u_div_sin (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (b_v_q),
    .num_i   (b_pi_q),
    .den_i   (b_m_q.work.eta_t),
    .side_i  (b_m_q),
    .valid_o (d1_v),
    .quo_o   (d1_quo),
    .side_o  (d1_m)
  );

  always_comb begin
    logic [2*fr_pkg::FRAC-1:0] ssq;
    ssq   = d1_quo[0] * d1_quo[0];
    c_x_d = fr_pkg::SQ_ONE - fr_pkg::SQ_IN_W'(ssq);
  end

  fr_sqrt_pipe #(
    .IN_W   (fr_pkg::SQ_IN_W),
    .SIDE_W ($bits(mid_t))
  ) u_sqrt_cos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (c_v_q),
    .rad_i   (c_x_q),
    .side_i  (c_m_q),
    .valid_o (s2_v),
    .root_o  (s2_root),
    .side_o  (s2_m)
  );

  // Normalize numerator and denominator together, then scale the numerator up.
  always_comb begin
    logic [fr_pkg::PROD_W-1:0] ns, np;
    logic [fr_pkg::DEN_W-1:0]  ds, dp;
    ns = f_ns_q >> f_ss_q;
    np = f_np_q >> f_sp_q;
    ds = f_ds_q >> f_ss_q;
    dp = f_dp_q >> f_sp_q;
    g_num_d[0] = {ns[fr_pkg::NORM_W-1:0], {fr_pkg::R_Q{1'b0}}};
    g_num_d[1] = {np[fr_pkg::NORM_W-1:0], {fr_pkg::R_Q{1'b0}}};
    g_den_d[0] = ds[fr_pkg::NORM_W-1:0];
    g_den_d[1] = dp[fr_pkg::NORM_W-1:0];
  end

  fr_div_pipe #(
    .NW     (DIV2_N),
    .DW     (fr_pkg::NORM_W),
    .QB     (fr_pkg::R_W),
    .LANES  (2),
    .SIDE_W (2)
  ) u_div_coef (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (g_v_q),
    .num_i   (g_num_q),
    .den_i   (g_den_q),
    .side_i  ({g_tir_q, g_zero_q}),
    .valid_o (d2_v),
    .quo_o   (d2_quo),
    .side_o  (d2_flags)
  );

  // Mean of the squared coefficients, truncated to the output format and saturated.
  always_comb begin
    logic [2*fr_pkg::R_W:0]   sum;
    logic [2*fr_pkg::R_W-1:0] kr;
    sum = {1'b0, h_ss_q} + {1'b0, h_sp_q};
    kr  = sum[2*fr_pkg::R_W:1] >> fr_pkg::KR_SHIFT;
    if (h_tir_q || h_zero_q || (kr > (2*fr_pkg::R_W)'(fr_pkg::REFL_ONE))) begin
      out_d.reflectance = fr_pkg::REFL_ONE;
    end else begin
      out_d.reflectance = kr[fr_pkg::OUT_WIDTH-1:0];
    end
    out_d.total_internal = h_tir_q;
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      c_v_q   <= 1'b0;
      d_v_q   <= 1'b0;
      e_v_q   <= 1'b0;
      f_v_q   <= 1'b0;
      g_v_q   <= 1'b0;
      h_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      a_v_q   <= !empty_i;
      b_v_q   <= s1_v;
      c_v_q   <= d1_v;
      d_v_q   <= s2_v;
      e_v_q   <= d_v_q;
      f_v_q   <= e_v_q;
      g_v_q   <= f_v_q;
      h_v_q   <= d2_v;
      out_v_q <= h_v_q;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_x_q    <= a_x_d;
      a_w_q    <= head_i;
      b_pi_q   <= b_pi_d;
      b_m_q    <= b_m_d;
      c_x_q    <= c_x_d;
      c_m_q    <= d1_m;
      d_tir_q  <= s2_m.tir;
      d_as_q   <= s2_m.work.eta_t * s2_m.work.cos_i;
      d_bs_q   <= s2_m.work.eta_i * s2_root;
      d_ap_q   <= s2_m.work.eta_i * s2_m.work.cos_i;
      d_bp_q   <= s2_m.work.eta_t * s2_root;
      e_tir_q  <= d_tir_q;
      e_ns_q   <= (d_as_q > d_bs_q) ? d_as_q - d_bs_q : d_bs_q - d_as_q;
      e_np_q   <= (d_ap_q > d_bp_q) ? d_ap_q - d_bp_q : d_bp_q - d_ap_q;
      e_ds_q   <= {1'b0, d_as_q} + {1'b0, d_bs_q};
      e_dp_q   <= {1'b0, d_ap_q} + {1'b0, d_bp_q};
      e_zero_q <= ((d_as_q | d_bs_q) == '0) || ((d_ap_q | d_bp_q) == '0);
      f_tir_q  <= e_tir_q;
      f_zero_q <= e_zero_q;
      f_ns_q   <= e_ns_q;
      f_np_q   <= e_np_q;
      f_ds_q   <= e_ds_q;
      f_dp_q   <= e_dp_q;
      f_ss_q   <= norm_shift(e_ds_q);
      f_sp_q   <= norm_shift(e_dp_q);
      g_tir_q  <= f_tir_q;
      g_zero_q <= f_zero_q;
      g_num_q  <= g_num_d;
      g_den_q  <= g_den_d;
      h_tir_q  <= d2_flags[1];
      h_zero_q <= d2_flags[0];
      h_ss_q   <= d2_quo[0] * d2_quo[0];
      h_sp_q   <= d2_quo[1] * d2_quo[1];
      out_q    <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/fresnel_reflectance.sv =====
// Top level of the unpolarized Fresnel reflectance block.
// Depends on fr_pkg, fr_front, fr_queue and fr_back.
//
// Each input transaction carries a unit ray direction, a unit surface normal (signed
// Q2.14) and an inside flag; each result transaction carries the reflectance in Q1.15
// (32768 is 1.0) and a total internal reflection flag. The block takes one transaction
// per cycle while in_stall_o is low and returns one result per input in order. Most of
// the pipeline lies in the back end, which runs two 15-stage square root pipelines and
// two divider pipelines of 14 and 16 stages in series, each resolving two bits per
// stage. A four-entry queue separates the front end from the back end, so output
// stalls back up into the input only once that queue fills. The outer and inner
// refractive indices (unsigned Q2.14, reset to 1.0 and 1.1) are to be written through
// the configuration port only while no transaction is in flight; the user must keep
// to this, as the block itself does not enforce it.
module fresnel_reflectance (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_addr_i,
  input  logic [fr_pkg::VEC_WIDTH-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  fr_pkg::in_item_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output fr_pkg::out_item_t             out_data_o
);

  logic [fr_pkg::VEC_WIDTH-1:0] outer_q, inner_q;
  logic                         push, pop, empty;
  fr_pkg::work_t                push_data, head;
  logic [fr_pkg::QCNT_W-1:0]    q_count;

  // Index registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outer_q <= fr_pkg::OUTER_RESET;
      inner_q <= fr_pkg::INNER_RESET;
    end else if (cfg_we_i) begin
      unique case (fr_pkg::reg_idx_e'(cfg_addr_i))
        fr_pkg::REG_OUTER: outer_q <= cfg_wdata_i;
        fr_pkg::REG_INNER: inner_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  fr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .outer_i     (outer_q),
    .inner_i     (inner_q),
    .q_count_i   (q_count),
    .push_o      (push),
    .push_data_o (push_data)
  );

  fr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty),
    .count_o     (q_count)
  );

  fr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/fr_checker.sv =====
// Port-level checks for fresnel_reflectance, bound to the top level.
// Depends on fr_pkg and fresnel_reflectance.
module fresnel_reflectance_sva (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input fr_pkg::out_item_t             out_data_o
);

  // No result transaction is offered while reset is held.
  a_no_out_in_reset: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result offered during reset");

  // Total internal reflection always reports full reflectance.
  a_tir_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.total_internal |-> out_data_o.reflectance == fr_pkg::REFL_ONE)
    else $error("total internal reflection without full reflectance");

  // Reflectance never exceeds one.
  a_refl_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.reflectance <= fr_pkg::REFL_ONE)
    else $error("reflectance above one");

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind fresnel_reflectance fresnel_reflectance_sva u_fr_checker (.*);
